[rtl/mlfq_pkg.sv]
// ----------------------------------------------------------------------------
// mlfq_pkg
// shared types and constants for the feedback scheduler
// ----------------------------------------------------------------------------
package mlfq_pkg;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_SELECT  = 1'b1;

   localparam int CLASSES    = 4;
   localparam int CLASS_W    = 2;
   localparam int BURST_W    = 16;
   localparam int RUNTIME_W  = 32;
   localparam int LEVEL_W    = 4;
   localparam int SLICE_W    = 10;

   // one classified item between front and back
   typedef struct packed {
      logic                 op;
      logic [9:0]           thread_id;
      logic [CLASS_W-1:0]   priority_class;
      logic [BURST_W-1:0]   burst_length;
   } cmd_type;

endpackage

[rtl/mlfq_ram.sv]
// ----------------------------------------------------------------------------
// mlfq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mlfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/mlfq_front.sv]
// ----------------------------------------------------------------------------
// mlfq_front
// input stage and two-entry command queue toward the scheduler core
// ----------------------------------------------------------------------------
module mlfq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [5:0]        req_thread_id,
   input  logic [1:0]        req_priority_class,
   input  logic [15:0]       req_burst_length,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output mlfq_pkg::cmd_type cmd
);
   mlfq_pkg::cmd_type q_ff [2];
   mlfq_pkg::cmd_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = q_ff[0];

   always_comb begin
      q_in.op             = req_op;
      q_in.thread_id      = {4'd0, req_thread_id};
      q_in.priority_class = req_priority_class;
      q_in.burst_length   = req_burst_length;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      if (pop) begin
         q_ff[0] <= (cnt_ff == 2'd2) ? q_ff[1] : q_in;
         if (push) q_ff[1] <= q_in;
      end else if (push) begin
         if (cnt_ff == 2'd0) q_ff[0] <= q_in;
         else                q_ff[1] <= q_in;
      end
   end
endmodule

[rtl/mlfq_back.sv]
// ----------------------------------------------------------------------------
// mlfq_back
// scheduler core: thread table, linked lists per level and class
// ----------------------------------------------------------------------------
module mlfq_back #(
   parameter int THREADS = 64,
   parameter int LEVELS  = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  mlfq_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_selected,
   output logic [5:0]        rsp_chosen_thread,
   output logic [3:0]        rsp_chosen_level,
   output logic [1:0]        rsp_chosen_class,
   output logic [9:0]        rsp_quantum,
   output logic [31:0]       rsp_runtime_before,
   output logic [6:0]        rsp_ready_count
);
   localparam int TW    = $clog2(THREADS);
   localparam int LISTS = LEVELS * mlfq_pkg::CLASSES;
   localparam int LW    = $clog2(LISTS);
   localparam int CW    = $clog2(THREADS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD   = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;
   mlfq_pkg::cmd_type cur_ff;
   logic [THREADS-1:0] waiting_ff;
   logic [THREADS-1:0] touched_ff;   // level/runtime valid
   logic [LISTS-1:0]   nonempty_ff;
   logic [CW-1:0]      total_ff, total_in;
   logic [LW-1:0]      lst_ff;
   logic [TW-1:0]      tid_ff;
   logic               found_ff;

   // memories
   logic            lvl_we, rt_we, info_we, nxt_we, hd_we, tl_we;
   logic [TW-1:0]   lvl_wa, rt_wa, info_wa, nxt_wa, lvl_ra, rt_ra, info_ra, nxt_ra;
   logic [LW-1:0]   hd_wa, tl_wa, hd_ra, tl_ra;
   logic [3:0]      lvl_wd, lvl_rd;
   logic [31:0]     rt_wd, rt_rd;
   logic [17:0]     info_wd, info_rd;
   logic [TW-1:0]   nxt_wd, nxt_rd, hd_wd, hd_rd, tl_wd, tl_rd;

   mlfq_ram #(.WIDTH(4),  .DEPTH(THREADS)) u_lvl (clock, lvl_we, lvl_wa, lvl_wd, lvl_ra, lvl_rd);
   mlfq_ram #(.WIDTH(32), .DEPTH(THREADS)) u_rt (clock, rt_we, rt_wa, rt_wd, rt_ra, rt_rd);
   mlfq_ram #(.WIDTH(18), .DEPTH(THREADS)) u_info (clock, info_we, info_wa, info_wd, info_ra,
                                                   info_rd);
   mlfq_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_nxt (clock, nxt_we, nxt_wa, nxt_wd, nxt_ra, nxt_rd);
   mlfq_ram #(.WIDTH(TW), .DEPTH(LISTS)) u_hd (clock, hd_we, hd_wa, hd_wd, hd_ra, hd_rd);
   mlfq_ram #(.WIDTH(TW), .DEPTH(LISTS)) u_tl (clock, tl_we, tl_wa, tl_wd, tl_ra, tl_rd);

   // first nonempty list
   logic          any_ne;
   logic [LW-1:0] first_ne;
   always_comb begin
      any_ne   = 1'b0;
      first_ne = '0;
      for (int i = LISTS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            any_ne   = 1'b1;
            first_ne = LW'(i);
         end
      end
   end

   // enqueue level decision from read data
   logic [3:0]  cur_lvl;
   logic [31:0] cur_rt;
   logic        demote;
   logic [3:0]  new_lvl;
   logic [LW-1:0] enq_lst;
   logic [32:0] rt_sum;
   logic [TW-1:0] head_t;
   always_comb begin
      cur_lvl = touched_ff[tid_ff] ? lvl_rd : 4'd0;
      cur_rt  = touched_ff[tid_ff] ? rt_rd : 32'd0;
      demote  = ((33'd1 << cur_lvl) <= {1'b0, cur_rt}) && (32'(cur_lvl) < 32'(LEVELS - 1));
      new_lvl = demote ? cur_lvl + 4'd1 : cur_lvl;
      enq_lst = LW'(32'(new_lvl) * mlfq_pkg::CLASSES + 32'(cur_ff.priority_class));
      head_t  = hd_rd;
      rt_sum  = {1'b0, cur_rt} + {17'd0, info_rd[15:0]};
   end

   logic enq_ok;
   assign enq_ok = (32'(cur_ff.thread_id) < THREADS) &&
                   !waiting_ff[cur_ff.thread_id[TW-1:0]];

   // waiting count after the current transaction
   always_comb begin
      total_in = total_ff;
      if (cur_ff.op == mlfq_pkg::OP_ENQUEUE) begin
         if (enq_ok) total_in = total_ff + CW'(1);
      end else if (found_ff) begin
         total_in = total_ff - CW'(1);
      end
   end

   assign cmd_take = (state_ff == ST_IDLE);

   logic [LW-1:0] enq_lst_ff;

   always_comb begin
      state_in = state_ff;
      lvl_we = 1'b0; rt_we = 1'b0; info_we = 1'b0; nxt_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0;
      lvl_wa = tid_ff; rt_wa = tid_ff; info_wa = tid_ff; nxt_wa = tl_rd;
      lvl_wd = new_lvl; rt_wd = 32'd0;
      info_wd = {cur_ff.priority_class, cur_ff.burst_length};
      nxt_wd = tid_ff; hd_wa = enq_lst_ff; tl_wa = enq_lst_ff; hd_wd = tid_ff; tl_wd = tid_ff;
      lvl_ra = cmd.thread_id[TW-1:0]; rt_ra = cmd.thread_id[TW-1:0];
      info_ra = cmd.thread_id[TW-1:0]; nxt_ra = '0;
      hd_ra = first_ne; tl_ra = first_ne;
      unique case (state_ff)
         ST_IDLE: if (cmd_valid) state_in = ST_RD;
         ST_RD: begin
            // select: head data ready, read the head thread's entries and its list tail
            // enqueue: keep the thread's own entries, read the tail of its new list
            if (cur_ff.op == mlfq_pkg::OP_SELECT) begin
               lvl_ra = head_t; rt_ra = head_t; info_ra = head_t; nxt_ra = head_t;
               tl_ra = lst_ff;
            end else begin
               lvl_ra = tid_ff; rt_ra = tid_ff; info_ra = tid_ff;
               tl_ra = enq_lst;
            end
            state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // writes happen in ST_EXEC
      if (state_ff == ST_EXEC) begin
         if (cur_ff.op == mlfq_pkg::OP_ENQUEUE) begin
            if (enq_ok) begin
               lvl_we = 1'b1;
               rt_we = demote || !touched_ff[tid_ff];
               rt_wd = demote ? 32'd0 : cur_rt;
               info_we = 1'b1;
               tl_we = 1'b1;
               hd_we = !nonempty_ff[enq_lst_ff];
               nxt_we = nonempty_ff[enq_lst_ff];
            end
         end else if (found_ff) begin
            rt_we = 1'b1;
            rt_wd = rt_sum[32] ? 32'hFFFF_FFFF : rt_sum[31:0];
            lvl_we = !touched_ff[tid_ff];
            lvl_wd = 4'd0;
            hd_wa = lst_ff;
            hd_wd = nxt_rd;
            hd_we = (tl_rd != tid_ff);
         end
      end
   end

   logic [3:0]    sel_lvl;
   assign sel_lvl = 4'(32'(lst_ff) / mlfq_pkg::CLASSES);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         waiting_ff  <= '0;
         touched_ff  <= '0;
         nonempty_ff <= '0;
         total_ff    <= '0;
         rsp_valid   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && cmd_valid) begin
            cur_ff   <= cmd;
            tid_ff   <= cmd.thread_id[TW-1:0];
            lst_ff   <= first_ne;
            found_ff <= any_ne;
         end
         if (state_ff == ST_RD && cur_ff.op == mlfq_pkg::OP_SELECT) tid_ff <= head_t;
         if (state_ff == ST_RD) enq_lst_ff <= enq_lst;
         if (state_ff == ST_EXEC) begin
            rsp_valid <= 1'b1;
            total_ff <= total_in;
            rsp_ready_count <= 7'(total_in);
            if (cur_ff.op == mlfq_pkg::OP_SELECT && found_ff) begin
               rsp_selected <= 1'b1;
               rsp_chosen_thread <= 6'(tid_ff);
               rsp_chosen_level <= sel_lvl;
               rsp_chosen_class <= info_rd[17:16];
               rsp_quantum <= 10'(11'd1 << sel_lvl);
               rsp_runtime_before <= cur_rt;
            end else begin
               rsp_selected <= 1'b0; rsp_chosen_thread <= '0; rsp_chosen_level <= '0;
               rsp_chosen_class <= '0; rsp_quantum <= '0; rsp_runtime_before <= '0;
            end
            if (cur_ff.op == mlfq_pkg::OP_ENQUEUE) begin
               if (enq_ok) begin
                  waiting_ff[tid_ff] <= 1'b1;
                  touched_ff[tid_ff] <= 1'b1;
                  nonempty_ff[enq_lst_ff] <= 1'b1;
               end
            end else if (found_ff) begin
               waiting_ff[tid_ff] <= 1'b0;
               touched_ff[tid_ff] <= 1'b1;
               if (tl_rd == tid_ff) nonempty_ff[lst_ff] <= 1'b0;
            end
         end
         if (state_ff == ST_OUT && rsp_ready) rsp_valid <= 1'b0;
      end
   end
endmodule

[rtl/multilevel_feedback_queue_scheduler.sv]
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// feedback scheduler with per-level, per-class linked thread lists
// ----------------------------------------------------------------------------
// each transaction steps through the core states issue, memory read, update and result
// hold until taken; the thread table and list head/tail memories are read
// synchronously, so a select needs the head read before the thread read.
// a two-entry command queue in front accepts transactions while the core works.
// per-thread level and runtime use valid bits cleared at reset, no clear pass.
module multilevel_feedback_queue_scheduler #(
   parameter int THREADS = 64,
   parameter int LEVELS  = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [5:0]  req_thread_id,
   input  logic [1:0]  req_priority_class,
   input  logic [15:0] req_burst_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_selected,
   output logic [5:0]  rsp_chosen_thread,
   output logic [3:0]  rsp_chosen_level,
   output logic [1:0]  rsp_chosen_class,
   output logic [9:0]  rsp_quantum,
   output logic [31:0] rsp_runtime_before,
   output logic [6:0]  rsp_ready_count
);
   // front to back command link
   logic              cmd_valid, cmd_take;
   mlfq_pkg::cmd_type cmd;

   mlfq_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_thread_id,
      .req_priority_class, .req_burst_length, .cmd_valid, .cmd_take, .cmd
   );

   mlfq_back #(.THREADS(THREADS), .LEVELS(LEVELS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd, .rsp_valid, .rsp_ready,
      .rsp_selected, .rsp_chosen_thread, .rsp_chosen_level, .rsp_chosen_class,
      .rsp_quantum, .rsp_runtime_before, .rsp_ready_count
   );
endmodule
